[design/hpt_pkg.sv]
// ---------------------------------------------------------------------------
// Homogeneous point transform package
// Shared widths, result record and saturation constants for the transform
// datapath and its perspective divide lanes.
// ---------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

   // Fixed field widths.
   localparam int COORD_W    = 32;
   localparam int REG_W      = 64;
   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int PROD_W     = 2 * COORD_W;

   // A sum of four products fits in 66 signed bits; its magnitude in 65.
   localparam int SUM_W = 66;
   localparam int MAG_W = SUM_W - 1;

   // The divider resolves 33 quotient bits, one per stage.
   localparam int QBITS = COORD_W + 1;
   localparam int REM_W = MAG_W + QBITS + 1;

   // Divide lane depth: prepare, range check, QBITS steps, output register.
   localparam int LANE_LAT = QBITS + 3;

   localparam logic [QBITS-1:0]   LIMIT_POS = 33'h0_7FFF_FFFF;
   localparam logic [QBITS-1:0]   LIMIT_NEG = 33'h0_8000_0000;
   localparam logic [COORD_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_NEG   = 32'h8000_0000;

   typedef logic signed [SUM_W-1:0] sum_type;

   // One divide lane's result.
   typedef struct packed {
      logic [COORD_W-1:0] quot;
      logic               ovf;
      logic               w_zero;
   } lane_out_type;

endpackage

`default_nettype wire

[design/hpt_matmul.sv]
// ---------------------------------------------------------------------------
// Homogeneous point transform: matrix multiply
// Two register stages: twelve 32x32 products, then the four column sums
// with the w = 1 row added as a shifted coefficient.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_matmul #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          en,
   input  wire logic                                          in_vld,
   input  wire logic signed [hpt_pkg::COORD_W-1:0]            in_x,
   input  wire logic signed [hpt_pkg::COORD_W-1:0]            in_y,
   input  wire logic signed [hpt_pkg::COORD_W-1:0]            in_z,
   input  wire logic [hpt_pkg::NUM_REGS-1:0][hpt_pkg::REG_W-1:0] mat,
   output logic                                               out_vld,
   output hpt_pkg::sum_type                                   sums [4]
);

   logic signed [hpt_pkg::PROD_W-1:0]  prod_in  [3][4];
   logic signed [hpt_pkg::PROD_W-1:0]  prod_ff  [3][4];
   logic signed [hpt_pkg::COORD_W-1:0] trans_in [4];
   logic signed [hpt_pkg::COORD_W-1:0] trans_ff [4];
   logic signed [hpt_pkg::COORD_W-1:0] coord    [3];
   hpt_pkg::sum_type                   sum_in   [4];
   hpt_pkg::sum_type                   sum_ff   [4];
   logic                               vld1_ff, vld2_ff;

   assign coord[0] = in_x;
   assign coord[1] = in_y;
   assign coord[2] = in_z;

   // Coefficient (r, c) sits in register 2r + c/2, odd columns in the high half.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = coord[r] *
               $signed(mat[r*2 + c/2][(c%2)*hpt_pkg::COORD_W +: hpt_pkg::COORD_W]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         trans_in[c] = $signed(mat[6 + c/2][(c%2)*hpt_pkg::COORD_W +: hpt_pkg::COORD_W]);
      end
   end

   // Column sums; the translation row is scaled by w = 1.0.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = hpt_pkg::sum_type'(prod_ff[0][c]) + hpt_pkg::sum_type'(prod_ff[1][c])
                   + hpt_pkg::sum_type'(prod_ff[2][c])
                   + (hpt_pkg::sum_type'(trans_ff[c]) <<< FRAC_BITS);
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         trans_ff <= trans_in;
         sum_ff   <= sum_in;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   assign out_vld = vld2_ff;
   assign sums    = sum_ff;

endmodule

`default_nettype wire

[design/hpt_div_lane.sv]
// ---------------------------------------------------------------------------
// Homogeneous point transform: divide lane
// Pipelined restoring divider for one coordinate: sign split, range check,
// one quotient bit per stage, then sign restore and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module hpt_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  hpt_pkg::sum_type           num,
   input  hpt_pkg::sum_type           den,
   output hpt_pkg::lane_out_type      result
);

   localparam int QB = hpt_pkg::QBITS;

   logic [hpt_pkg::SUM_W-1:0] num_abs, den_abs;

   // Prepare stage.
   logic [hpt_pkg::REM_W-1:0] pn_ff;
   logic [hpt_pkg::MAG_W-1:0] pd_ff;
   logic                      pneg_ff, pwz_ff;

   // Step stages, index 0 is the range check.
   logic [hpt_pkg::REM_W-1:0] rem_in [QB+1];
   logic [hpt_pkg::REM_W-1:0] rem_ff [QB+1];
   logic [QB-1:0]             q_in   [QB+1];
   logic [QB-1:0]             q_ff   [QB+1];
   logic [hpt_pkg::MAG_W-1:0] d_ff   [QB+1];
   logic                      neg_ff [QB+1];
   logic                      wz_ff  [QB+1];
   logic                      ovf_ff [QB+1];
   logic                      ovf_in;
   logic [hpt_pkg::REM_W-1:0] dsh    [QB+1];

   hpt_pkg::lane_out_type     res_in, res_ff;
   logic [QB-1:0]             limit;

   assign num_abs = num[hpt_pkg::SUM_W-1] ? -num : num;
   assign den_abs = den[hpt_pkg::SUM_W-1] ? -den : den;

   // Quotients of 2^33 or more are caught before the steps start.
   assign ovf_in = pn_ff >= (hpt_pkg::REM_W'(pd_ff) << QB);

   // One compare and subtract per quotient bit, most significant first.
   always_comb begin
      rem_in[0] = pn_ff;
      q_in[0]   = '0;
      dsh[0]    = '0;
      for (int s = 1; s <= QB; s++) begin
         dsh[s] = hpt_pkg::REM_W'(d_ff[s-1]) << (QB - s);
         if (rem_ff[s-1] >= dsh[s]) begin
            rem_in[s] = rem_ff[s-1] - dsh[s];
            q_in[s]   = q_ff[s-1] | (QB'(1) << (QB - s));
         end else begin
            rem_in[s] = rem_ff[s-1];
            q_in[s]   = q_ff[s-1];
         end
      end
   end

   // Sign restore and saturation.
   assign limit = neg_ff[QB] ? hpt_pkg::LIMIT_NEG : hpt_pkg::LIMIT_POS;

   always_comb begin
      res_in.w_zero = wz_ff[QB];
      if (wz_ff[QB]) begin
         res_in.quot = '0;
         res_in.ovf  = 1'b0;
      end else if (ovf_ff[QB] || (q_ff[QB] > limit)) begin
         res_in.quot = neg_ff[QB] ? hpt_pkg::SAT_NEG : hpt_pkg::SAT_POS;
         res_in.ovf  = 1'b1;
      end else begin
         res_in.quot = neg_ff[QB] ? -q_ff[QB][hpt_pkg::COORD_W-1:0]
                                  :  q_ff[QB][hpt_pkg::COORD_W-1:0];
         res_in.ovf  = 1'b0;
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (en) begin
         pn_ff   <= hpt_pkg::REM_W'(num_abs[hpt_pkg::MAG_W-1:0]) << FRAC_BITS;
         pd_ff   <= den_abs[hpt_pkg::MAG_W-1:0];
         pneg_ff <= num[hpt_pkg::SUM_W-1] ^ den[hpt_pkg::SUM_W-1];
         pwz_ff  <= (den == '0);
         for (int s = 0; s <= QB; s++) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
         end
         d_ff[0]   <= pd_ff;
         neg_ff[0] <= pneg_ff;
         wz_ff[0]  <= pwz_ff;
         ovf_ff[0] <= ovf_in;
         for (int s = 1; s <= QB; s++) begin
            d_ff[s]   <= d_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            wz_ff[s]  <= wz_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

[design/homogeneous_point_transform.sv]
// Pipeline: 2 multiply/sum stages, then 36 divide stages of which 33
// resolve one quotient bit each.
// Throughput: one point per cycle; the pipeline advances as one, so a held
// result stalls every stage behind it.
// Reset: synchronous, clears all valid bits and loads the identity matrix.
// ---------------------------------------------------------------------------
// Homogeneous point transform
// Multiplies (x, y, z, 1) by a configurable 4x4 Q matrix and divides the
// first three sums by w, with zero-w and saturation flags.
// ---------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Fields from bit 0: in_x, in_y, in_z.
   input  wire logic [95:0]                       req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: out_x, out_y, out_z.
   output logic [95:0]                            rsp_tdata,
   // Fields from bit 0: w_zero, overflow.
   output logic [1:0]                             rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [hpt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [hpt_pkg::REG_W-1:0]         csr_wdata
);

   localparam int CW = hpt_pkg::COORD_W;

   // Identity matrix: a 1.0 in the low or high half of a register.
   localparam logic [hpt_pkg::REG_W-1:0] ONE_LO  = hpt_pkg::REG_W'(1) << FRAC_BITS;
   localparam logic [hpt_pkg::REG_W-1:0] ONE_HI  = hpt_pkg::REG_W'(1) << (CW + FRAC_BITS);
   localparam logic [hpt_pkg::REG_W-1:0] NO_COEF = '0;
   localparam logic [hpt_pkg::NUM_REGS-1:0][hpt_pkg::REG_W-1:0] MAT_RESET =
      {ONE_HI, NO_COEF, ONE_LO, NO_COEF, NO_COEF, ONE_HI, NO_COEF, ONE_LO};

   logic [hpt_pkg::NUM_REGS-1:0][hpt_pkg::REG_W-1:0] mat_ff;
   logic                                             en;
   logic                                             mm_vld;
   hpt_pkg::sum_type                                 sums [4];
   hpt_pkg::lane_out_type                            lane_res [3];
   logic [hpt_pkg::LANE_LAT-1:0]                     vld_ff;

   // Matrix registers; indexes past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else if (csr_we && (csr_addr < hpt_pkg::CSR_ADDR_W'(hpt_pkg::NUM_REGS))) begin
         mat_ff[csr_addr[hpt_pkg::REG_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // The whole pipeline moves unless a result is held at the output.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   hpt_matmul #(.FRAC_BITS(FRAC_BITS)) u_matmul (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .in_x    ($signed(req_tdata[CW-1:0])),
      .in_y    ($signed(req_tdata[2*CW-1:CW])),
      .in_z    ($signed(req_tdata[3*CW-1:2*CW])),
      .mat     (mat_ff),
      .out_vld (mm_vld),
      .sums    (sums)
   );

   // One divide lane per coordinate, all sharing w as divisor.
   for (genvar g = 0; g < 3; g++) begin : g_lane
      hpt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .en     (en),
         .num    (sums[g]),
         .den    (sums[3]),
         .result (lane_res[g])
      );
   end

   // Valid bits alongside the divide lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[hpt_pkg::LANE_LAT-2:0], mm_vld};
      end
   end

   assign rsp_tvalid = vld_ff[hpt_pkg::LANE_LAT-1];
   assign rsp_tdata  = {lane_res[2].quot, lane_res[1].quot, lane_res[0].quot};
   assign rsp_tuser  = {lane_res[0].ovf | lane_res[1].ovf | lane_res[2].ovf,
                        lane_res[0].w_zero & lane_res[1].w_zero & lane_res[2].w_zero};

   // A zero w gives zero coordinates and no overflow.
   a_wzero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("zero w result carries data or overflow");

   // A held result stalls the input side.
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   // Nothing leaves the pipeline right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

[verif/tb.sv]
// ---------------------------------------------------------------------------
// Homogeneous point transform testbench
// Streams points through the transform under several matrix settings and
// handshake patterns, predicts each result with an exact 128-bit model of
// the multiply, sum and perspective divide, and checks every field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int LATENCY = 38;

   // Register indexes of the matrix.
   localparam logic [hpt_pkg::CSR_ADDR_W-1:0] R0C01 = 4'd0, R0C23 = 4'd1, R1C01 = 4'd2,
      R1C23 = 4'd3, R2C01 = 4'd4, R2C23 = 4'd5, R3C01 = 4'd6, R3C23 = 4'd7,
      BAD_IDX = 4'd9;

   typedef struct packed {
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } point_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        w_zero;
      logic        overflow;
   } proj_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [95:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [hpt_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [hpt_pkg::REG_W-1:0] csr_wdata = '0;

   point_type pending_points[$];
   proj_type expected_proj[$];
   logic [63:0] matrix[8];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int points_sent = 0;
   int results_seen = 0;
   int settings_used = 0;

   homogeneous_point_transform #(.FRAC_BITS(FRAC)) uut (.*);

   always #5 clock = ~clock;

   function automatic logic signed [127:0] coef_of(int r, int c);
      logic [63:0] v;
      v = matrix[r*2 + c/2];
      return (c % 2) ? 128'(signed'(v[63:32])) : 128'(signed'(v[31:0]));
   endfunction

   // Quotient of num by den in Q16.16, truncated toward zero and saturated.
   function automatic logic [31:0] divide_q(logic signed [127:0] num,
                                            logic signed [127:0] den,
                                            inout logic ovf);
      logic neg;
      logic [127:0] n, d, q;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      q = (n << FRAC) / d;
      if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
         ovf = 1'b1;
         return neg ? hpt_pkg::SAT_NEG : hpt_pkg::SAT_POS;
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   function automatic proj_type project_point(point_type p);
      logic signed [127:0] v[4], s[4];
      proj_type o;
      logic ovf;
      v[0] = 128'(signed'(p.x));
      v[1] = 128'(signed'(p.y));
      v[2] = 128'(signed'(p.z));
      v[3] = 128'(1) << FRAC;
      for (int c = 0; c < 4; c++) begin
         s[c] = '0;
         for (int r = 0; r < 4; r++) s[c] += v[r] * coef_of(r, c);
      end
      o = '0;
      if (s[3] == '0) begin
         o.w_zero = 1'b1;
         return o;
      end
      ovf = 1'b0;
      o.x = divide_q(s[0], s[3], ovf);
      o.y = divide_q(s[1], s[3], ovf);
      o.z = divide_q(s[2], s[3], ovf);
      o.overflow = ovf;
      return o;
   endfunction

   // Driver: offers queued points, honoring the sender idle rate.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_proj.push_back(project_point(point_type'(req_tdata)));
            points_sent++;
            void'(pending_points.pop_front());
         end
         if (pending_points.size() > 0 && (req_tvalid && !req_tready ||
             $urandom_range(99) >= send_idle_pct)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_points[0];
         end else if (!(req_tvalid && !req_tready)) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver readiness: random stalls and an occasional long hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: compares each result transfer with the oldest prediction.
   always @(posedge clock) begin
      proj_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_proj.size() == 0) begin
            $error("result transfer with no prediction waiting");
            errors++;
         end else begin
            e = expected_proj.pop_front();
            if (rsp_tdata[31:0] !== e.x) begin
               $error("out_x expected %h got %h", e.x, rsp_tdata[31:0]); errors++;
            end
            if (rsp_tdata[63:32] !== e.y) begin
               $error("out_y expected %h got %h", e.y, rsp_tdata[63:32]); errors++;
            end
            if (rsp_tdata[95:64] !== e.z) begin
               $error("out_z expected %h got %h", e.z, rsp_tdata[95:64]); errors++;
            end
            if (rsp_tuser[0] !== e.w_zero) begin
               $error("w_zero expected %b got %b", e.w_zero, rsp_tuser[0]); errors++;
            end
            if (rsp_tuser[1] !== e.overflow) begin
               $error("overflow expected %b got %b", e.overflow, rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_points.size() > 0 || req_tvalid || expected_proj.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write; the write enable is low again when the task returns.
   task automatic write_reg(logic [hpt_pkg::CSR_ADDR_W-1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < hpt_pkg::NUM_REGS) matrix[idx] = val;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh8_0000);
         default: return 32'($signed($urandom_range(0, 16'hFFFF)) << 8);
      endcase
   endfunction

   task automatic load_matrix(int mode);
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
         write_reg(i[hpt_pkg::CSR_ADDR_W-1:0], {rand_coord(mode), rand_coord(mode)});
   endtask

   task automatic queue_random(int n, int mode);
      point_type p;
      for (int i = 0; i < n; i++) begin
         p.x = rand_coord(mode);
         p.y = rand_coord(mode);
         p.z = rand_coord(mode);
         pending_points.push_back(p);
      end
   endtask

   // Stimulus sequence.
   initial begin
      matrix[0] = 64'd65536;       matrix[1] = '0;
      matrix[2] = 64'd1 << 48;     matrix[3] = '0;
      matrix[4] = '0;              matrix[5] = 64'd65536;
      matrix[6] = '0;              matrix[7] = 64'd1 << 48;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points through the reset identity matrix.
      pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
      pending_points.push_back('{32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000});
      pending_points.push_back('{32'h0, 32'h0, 32'h7FFF_FFFF});
      drain();
      settings_used++;

      // Perspective matrix: w = z, which gives zero w, overflow and truncation.
      write_reg(R0C01, 64'd65536);
      write_reg(R1C01, 64'd1 << 48);
      write_reg(R2C23, {32'h0001_0000, 32'h0001_0000});
      write_reg(R3C23, 64'd0);
      write_reg(BAD_IDX, 64'hDEAD_BEEF);
      pending_points.push_back('{32'h0, 32'h0, 32'h0});
      pending_points.push_back('{32'h0003_0000, 32'h0001_0000, 32'h7FFF_FFFF});
      pending_points.push_back('{32'h0000_0001, 32'h0001_0000, 32'h7FFF_0000});
      pending_points.push_back('{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000});
      pending_points.push_back('{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
      pending_points.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0007});
      pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      drain();
      settings_used++;

      // Extreme coefficients everywhere.
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
         write_reg(i[hpt_pkg::CSR_ADDR_W-1:0], (i % 2) ? 64'h8000_0000_7FFF_FFFF :
                                                         64'h7FFF_FFFF_8000_0000);
      pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      pending_points.push_back('{32'h0, 32'h0, 32'h0});
      drain();
      settings_used++;

      // Random phases under each handshake pattern and matrix style.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         load_matrix(ph % 3);
         settings_used++;
         if (ph == 4) hold_off = 300;
         queue_random(220, (ph + 1) % 3);
         drain();
      end

      $display("Covered %0d points, %0d results, %0d matrix settings.",
               points_sent, results_seen, settings_used);
      if (errors == 0 && expected_proj.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
